/* rtl/core/gdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date query package
// Shared stage types, calendar tables and constant-divisor helpers.
// ----------------------------------------------------------------------------
package gdq_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // floor(t / 25) = (t * DIV25_MUL) >> DIV25_SHIFT for t below 4682.
    localparam logic [10:0] DIV25_MUL   = 11'd1311;
    localparam int          DIV25_SHIFT = 15;

    localparam logic [2:0] WD_FRIDAY   = 3'd5;
    localparam logic [2:0] WD_SATURDAY = 3'd6;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Stage 1: operands prepared, quotient products taken.
    typedef struct packed {
        logic [1:0]  year_lo;
        logic [11:0] year_q4;
        logic [22:0] year_prod;
        logic [23:0] y_prod;
        logic [14:0] y;
        logic [3:0]  m;
        logic [3:0]  month;
        logic [4:0]  day;
    } gdq_s1_t;

    // Stage 2: calendar decoded, weekday sum formed.
    typedef struct packed {
        logic [15:0] wd_sum;
        logic [8:0]  doy;
        logic        leap;
        logic [4:0]  mlen;
        logic [4:0]  day;
        logic        invalid;
    } gdq_s2_t;

    // Result word, most significant field first.
    typedef struct packed {
        logic        date_invalid;
        logic [8:0]  left_in_year;
        logic [4:0]  left_in_month;
        logic [2:0]  left_in_week;
        logic        business_day;
        logic        weekend_flag;
        logic        end_of_week;
        logic [4:0]  month_length;
        logic        leap_year;
        logic [2:0]  weekday;
    } gdq_res_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // (31 * m) / 12 for the shifted month number m (March is 1).
    function automatic logic [4:0] month_offset(input logic [3:0] m);
        logic [4:0] d;
        unique case (m)
            4'd1:    d = 5'd2;
            4'd2:    d = 5'd5;
            4'd3:    d = 5'd7;
            4'd4:    d = 5'd10;
            4'd5:    d = 5'd12;
            4'd6:    d = 5'd15;
            4'd7:    d = 5'd18;
            4'd8:    d = 5'd20;
            4'd9:    d = 5'd23;
            4'd10:   d = 5'd25;
            4'd11:   d = 5'd28;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/gdq_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date query, stage 1
// Shifts the year into March-based form and starts both divisions by 100.
// ----------------------------------------------------------------------------
module gdq_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gdq_pkg::YEAR_W-1:0]    year,
    input  logic [gdq_pkg::MONTH_W-1:0]   month,
    input  logic [gdq_pkg::DAY_W-1:0]     day,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gdq_pkg::gdq_s1_t              out_data
);
    import gdq_pkg::*;

    logic    valid_reg;
    gdq_s1_t data_reg;
    gdq_s1_t data_next;
    logic    early;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // January and February count as months 11 and 12 of the previous year.
    assign early = (month <= MONTH_FEB);

    always_comb begin
        data_next           = '0;
        data_next.year_lo   = year[1:0];
        data_next.year_q4   = year[13:2];
        data_next.y         = 15'(year) + 15'd400 - 15'(early);
        data_next.m         = early ? 4'(month + 4'd10) : 4'(month - 4'd2);
        data_next.month     = month;
        data_next.day       = day;
        data_next.year_prod = 23'(year[13:2]) * 23'(DIV25_MUL);
        data_next.y_prod    = 24'(data_next.y[14:2]) * 24'(DIV25_MUL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/core/gdq_cal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date query, stage 2
// Leap year, month length, range check, day of year and the weekday sum.
// ----------------------------------------------------------------------------
module gdq_cal (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gdq_pkg::gdq_s1_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output gdq_pkg::gdq_s2_t  out_data
);
    import gdq_pkg::*;

    logic       valid_reg;
    gdq_s2_t    data_reg;
    gdq_s2_t    data_next;
    logic [7:0] year_c;
    logic [7:0] y_c;
    logic [11:0] year_c25;
    logic       cent_year;
    logic       leap;
    logic [4:0] mlen;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        year_c   = in_data.year_prod[DIV25_SHIFT +: 8];
        y_c      = in_data.y_prod[DIV25_SHIFT +: 8];
        year_c25 = 12'({year_c, 4'b0}) + 12'({year_c, 3'b0}) + 12'(year_c);
        cent_year = (year_c25 == in_data.year_q4);
        leap     = (in_data.year_lo == 2'b00) && (!cent_year || (year_c[1:0] == 2'b00));
        mlen     = month_days(in_data.month, leap);

        data_next         = '0;
        data_next.leap    = leap;
        data_next.mlen    = mlen;
        data_next.day     = in_data.day;
        data_next.invalid = (mlen == 5'd0) || (in_data.day == 5'd0) || (in_data.day > mlen);
        data_next.doy     = days_before(in_data.month) + 9'(in_data.day)
                          + 9'(leap && (in_data.month > MONTH_FEB));
        data_next.wd_sum  = 16'(in_data.day) + 16'(in_data.y) + 16'(in_data.y[14:2])
                          - 16'(y_c) + 16'(y_c[7:2]) + 16'(month_offset(in_data.m));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/core/gdq_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date query, stage 3
// Reduces the weekday sum modulo 7 and forms the flags and remaining counts.
// ----------------------------------------------------------------------------
module gdq_finish (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gdq_pkg::gdq_s2_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output gdq_pkg::gdq_res_t out_data
);
    import gdq_pkg::*;

    logic     valid_reg;
    gdq_res_t data_reg;
    gdq_res_t data_next;
    logic [5:0] fold1;
    logic [3:0] fold2;
    logic [3:0] fold3;
    logic [2:0] wd;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        // Eight is one modulo seven, so octal digits can simply be summed.
        fold1 = 6'(in_data.wd_sum[2:0]) + 6'(in_data.wd_sum[5:3]) + 6'(in_data.wd_sum[8:6])
              + 6'(in_data.wd_sum[11:9]) + 6'(in_data.wd_sum[14:12]) + 6'(in_data.wd_sum[15]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
        fold3 = 4'(fold2[2:0]) + 4'(fold2[3]);
        wd    = (fold3 == 4'd7) ? 3'd0 : fold3[2:0];

        data_next              = '0;
        data_next.leap_year    = in_data.leap;
        data_next.month_length = in_data.mlen;
        data_next.date_invalid = in_data.invalid;
        if (!in_data.invalid) begin
            data_next.weekday       = wd;
            data_next.end_of_week   = (wd == WD_SATURDAY);
            data_next.weekend_flag  = (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
            data_next.business_day  = !((wd == WD_FRIDAY) || (wd == WD_SATURDAY));
            data_next.left_in_week  = WD_SATURDAY - wd;
            data_next.left_in_month = in_data.mlen - in_data.day + 5'd1;
            data_next.left_in_year  = (in_data.leap ? 9'd367 : 9'd366) - in_data.doy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/core/gregorian_date_query_core.sv */
`timescale 1ns / 1ps
// Path: an accepted word is registered in stage 1, then in stage 2 and stage 3, one
// register per stage; each of the three stages holds one word, and stage 3 drives m_tdata.
// Throughput: one word per clock cycle while m_tready is high.
// A stalled output holds only the stages behind it that are full, so bubbles close up.
// Reset: aresetn is synchronous and active low; it clears every stage valid bit,
// the data registers are not reset.
// ----------------------------------------------------------------------------
// Gregorian date query core
// Day of week, leap year, month length, week flags and remaining-day counts
// for one date per clock while the output is not stalled, in a three-stage pipeline.
// ----------------------------------------------------------------------------
module gregorian_date_query_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [13:0] year, [17:14] month, [22:18] day, [23] zero
    input  logic [gdq_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] weekday, [3] leap_year, [8:4] month_length, [9] end_of_week,
    // [10] weekend_flag, [11] business_day, [14:12] left_in_week,
    // [19:15] left_in_month, [28:20] left_in_year, [29] date_invalid, [31:30] zero
    output logic [gdq_pkg::M_DATA_W-1:0]    m_tdata
);
    import gdq_pkg::*;

    // Stage 1 takes the input word apart, folds January and February into the
    // previous year and starts the two divisions by 100 as reciprocal products.
    logic    s1_valid;
    logic    s1_ready;
    gdq_s1_t s1_data;

    // Stage 2 finishes the divisions, decides the leap year, checks the date
    // and forms the weekday sum and the day of the year.
    logic    s2_valid;
    logic    s2_ready;
    gdq_s2_t s2_data;

    // Stage 3 reduces the sum modulo seven and builds the result word. Its
    // register is the output register seen on m_tdata.
    gdq_res_t res;

    gdq_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .year      (s_tdata[13:0]),
        .month     (s_tdata[17:14]),
        .day       (s_tdata[22:18]),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    gdq_cal u_cal (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    gdq_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // The struct is declared most significant field first, matching the map above.
    assign m_tdata = {2'b00, res};

    // An accepted word always lands in the first stage.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> s1_valid)
        else $error("accepted word did not reach stage 1");

    // An invalid date carries zero weekday and zero counts.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.date_invalid |->
        (res.weekday == 3'd0) && (res.left_in_month == 5'd0) && (res.left_in_year == 9'd0))
        else $error("invalid date with nonzero fields");

    // A valid date has its remaining days in the month between one and the month length.
    a_month_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.date_invalid |->
        (res.left_in_month != 5'd0) && (res.left_in_month <= res.month_length)
        && (res.left_in_year != 9'd0))
        else $error("remaining-day count out of range");

    // Business day and weekend are exclusive for a valid date.
    a_week_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.date_invalid |-> (res.business_day != res.weekend_flag))
        else $error("business day and weekend flags disagree");

endmodule

/* tb/sv/gdq_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date query result checker
// Watches both stream channels, predicts each result word from the accepted
// date word and compares the two field by field, oldest first.
// ----------------------------------------------------------------------------
module gdq_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [13:0] year, [17:14] month, [22:18] day, [23] zero
    input  logic [gdq_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] weekday, [3] leap_year, [8:4] month_length, [9] end_of_week,
    // [10] weekend_flag, [11] business_day, [14:12] left_in_week,
    // [19:15] left_in_month, [28:20] left_in_year, [29] date_invalid, [31:30] zero
    input  logic [gdq_pkg::M_DATA_W-1:0]    m_tdata,
    output int                              fail_count,
    output int                              pending_count
);

    import gdq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    gdq_res_t expected_answers[$];

    function automatic int days_in_month(input int mo, input bit leap);
        case (mo)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            int'(MONTH_FEB):       return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic gdq_res_t predict_date_query(input logic [YEAR_W-1:0] yr,
                                                    input logic [MONTH_W-1:0] mo,
                                                    input logic [DAY_W-1:0] dy);
        gdq_res_t res;
        bit       leap;
        bit       bad;
        int       mlen;
        int       march_shift;
        int       y;
        int       m;
        int       wd;
        int       doy;
        leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
        mlen = days_in_month(int'(mo), leap);
        bad  = (mlen == 0) || (dy < 1) || (int'(dy) > mlen);
        res = '0;
        res.leap_year    = leap;
        res.month_length = mlen[4:0];
        res.date_invalid = bad;
        if (!bad) begin
            // January and February count as months 11 and 12 of the year before.
            // The extra 400 years keep the year positive without moving the weekday.
            march_shift = (mo <= MONTH_FEB) ? 1 : 0;
            y  = int'(yr) + 400 - march_shift;
            m  = int'(mo) + 12 * march_shift - 2;
            wd = (int'(dy) + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
            doy = int'(dy);
            for (int k = 1; k < int'(mo); k++)
                doy += days_in_month(k, leap);
            res.weekday       = wd[2:0];
            res.end_of_week   = (wd[2:0] == WD_SATURDAY);
            res.weekend_flag  = (wd[2:0] == WD_FRIDAY) || (wd[2:0] == WD_SATURDAY);
            res.business_day  = !res.weekend_flag;
            res.left_in_week  = 3'(6 - wd);
            res.left_in_month = 5'(mlen - int'(dy) + 1);
            res.left_in_year  = 9'((leap ? 366 : 365) - doy + 1);
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned seen);
        if (fail_count < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, seen);
        fail_count++;
    endtask

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge aclk) begin
        gdq_res_t want;
        gdq_res_t seen;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_answers.push_back(predict_date_query(s_tdata[13:0], s_tdata[17:14],
                                                              s_tdata[22:18]));
            if (m_tvalid && m_tready) begin
                seen = gdq_res_t'(m_tdata[29:0]);
                if (expected_answers.size() == 0) begin
                    note_mismatch("unexpected result word", 0, m_tdata);
                end else begin
                    want = expected_answers.pop_front();
                    if (seen.weekday !== want.weekday)
                        note_mismatch("weekday", want.weekday, seen.weekday);
                    if (seen.leap_year !== want.leap_year)
                        note_mismatch("leap_year", want.leap_year, seen.leap_year);
                    if (seen.month_length !== want.month_length)
                        note_mismatch("month_length", want.month_length, seen.month_length);
                    if (seen.end_of_week !== want.end_of_week)
                        note_mismatch("end_of_week", want.end_of_week, seen.end_of_week);
                    if (seen.weekend_flag !== want.weekend_flag)
                        note_mismatch("weekend_flag", want.weekend_flag, seen.weekend_flag);
                    if (seen.business_day !== want.business_day)
                        note_mismatch("business_day", want.business_day, seen.business_day);
                    if (seen.left_in_week !== want.left_in_week)
                        note_mismatch("left_in_week", want.left_in_week, seen.left_in_week);
                    if (seen.left_in_month !== want.left_in_month)
                        note_mismatch("left_in_month", want.left_in_month, seen.left_in_month);
                    if (seen.left_in_year !== want.left_in_year)
                        note_mismatch("left_in_year", want.left_in_year, seen.left_in_year);
                    if (seen.date_invalid !== want.date_invalid)
                        note_mismatch("date_invalid", want.date_invalid, seen.date_invalid);
                end
            end
            pending_count = expected_answers.size();
        end
    end

endmodule

/* tb/sv/tb_gregorian_date_query_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date query core testbench
// Drives directed and random dates into the core with random gaps on both
// channels; a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_gregorian_date_query_core;

    import gdq_pkg::*;

    // Cycles in a row without any accepted word before the run is declared hung.
    localparam int HANG_LIMIT     = 2000;
    localparam int RANDOM_DATES   = 1300;
    localparam int DRAIN_INTERVAL = 250;
    localparam int TAIL_CYCLES    = 8;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;

    int fail_count;
    int pending_count;
    int idle_cycles;

    // When set, both the sender and the receiver run without any gaps, so the
    // pipeline sees long stretches of back-to-back words.
    bit no_gaps;

    gregorian_date_query_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gdq_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 ns clock.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // The watchdog counts cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
    end

    initial begin
        wait (idle_cycles >= HANG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Number of days in a month, used only to steer the random dates toward
    // valid ones and toward month ends.
    function automatic int month_span(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo);
        bit leap;
        leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
        case (mo)
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            MONTH_FEB:               return leap ? 29 : 28;
            default:                 return 31;
        endcase
    endfunction

    // Sends one date word. The call starts and ends on a falling edge, so a
    // word that follows without a gap keeps tvalid high and only swaps tdata.
    task automatic send_date(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo,
                             input logic [DAY_W-1:0] dy);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {1'b0, dy, mo, yr};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Holds the sender off until every result word has come back.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    // Most random dates are valid ones, a good share of them on the last day
    // of the month; the rest are raw field values, of which only a minority are invalid.
    task automatic send_random_date();
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;
        logic [DAY_W-1:0]   dy;
        int                 pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            yr = 14'($urandom_range(0, 16383));
        else
            yr = 14'($urandom_range(1, 9999));
        if (pick < 80) begin
            mo = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
            if (pick < 15)
                dy = 5'(month_span(yr, mo));
            else
                dy = 5'($urandom_range(1, month_span(yr, mo)));
        end else begin
            mo = 4'($urandom_range(0, 15));
            dy = 5'($urandom_range(0, 31));
        end
        send_date(yr, mo, dy);
    endtask

    // The receiver takes a new random stall before each result word.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        idle_cycles = 0;
        no_gaps     = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed dates: field extremes, leap rules, month and year ends,
        // invalid months and days, and a Friday, Saturday, Sunday run.
        send_date(14'd1,     MONTH_JAN, 5'd1);
        send_date(14'd16383, MONTH_DEC, 5'd31);
        send_date(14'd0,     MONTH_FEB, 5'd29);
        send_date(14'd9999,  MONTH_DEC, 5'd31);
        send_date(14'd10000, MONTH_JAN, 5'd1);
        send_date(14'd2000,  MONTH_FEB, 5'd29);
        send_date(14'd1900,  MONTH_FEB, 5'd29);
        send_date(14'd2100,  MONTH_FEB, 5'd28);
        send_date(14'd2024,  MONTH_JAN, 5'd1);
        send_date(14'd2023,  MONTH_DEC, 5'd31);
        send_date(14'd2023,  4'd4,      5'd31);
        send_date(14'd2023,  4'd4,      5'd30);
        send_date(14'd2023,  4'd0,      5'd15);
        send_date(14'd2023,  4'd13,     5'd1);
        send_date(14'd2023,  4'd15,     5'd31);
        send_date(14'd2023,  4'd5,      5'd0);
        send_date(14'd2024,  4'd3,      5'd1);
        send_date(14'd2024,  MONTH_FEB, 5'd30);
        send_date(14'd2024,  4'd6,      5'd14);
        send_date(14'd2024,  4'd6,      5'd15);
        send_date(14'd2024,  4'd6,      5'd16);
        send_date(14'd8191,  4'd7,      5'd4);
        send_date(14'd4096,  4'd11,     5'd30);
        wait_drained();

        // Random dates in chunks; some chunks run without gaps on either side,
        // and every so often the sender waits for the pipeline to empty.
        for (int n = 0; n < RANDOM_DATES; n++) begin
            if (n % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (n % DRAIN_INTERVAL == DRAIN_INTERVAL - 1)
                wait_drained();
            send_random_date();
        end

        s_tvalid = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/gdq_pkg.sv
rtl/core/gdq_prep.sv
rtl/core/gdq_cal.sv
rtl/core/gdq_finish.sv
rtl/core/gregorian_date_query_core.sv
tb/sv/gdq_result_checker.sv
tb/sv/tb_gregorian_date_query_core.sv
